// ===== src/pls_pkg.sv =====
// package for the positional list store: function and status codes, sequencer states
package pls_pkg;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_RANGE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_MOV,
        ST_REM_CHK,
        ST_REM_MOV,
        ST_RD_WAIT,
        ST_FIRST,
        ST_LAST,
        ST_LAST_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== src/pls_ctrl.sv =====
// sequencer, element memory and shared index unit of the positional list store
module pls_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IDX_W     = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_func,
    input  logic [CNT_W-1:0]      in_position,
    input  logic [DATA_WIDTH-1:0] in_value,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [1:0]            res_status,
    output logic [DATA_WIDTH-1:0] res_read_value,
    output logic [CNT_W-1:0]      res_count,
    output logic [DATA_WIDTH-1:0] res_first,
    output logic [DATA_WIDTH-1:0] res_last
);

    pls_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [1:0]            status_reg, status_next;
    logic [DATA_WIDTH-1:0] rdval_reg, rdval_next;
    logic [DATA_WIDTH-1:0] first_reg, first_next;
    logic [DATA_WIDTH-1:0] last_reg, last_next;

    logic [DATA_WIDTH-1:0] slots [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [IDX_W-1:0]      raddr;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  we;

    logic                  step_up;
    logic [CNT_W-1:0]      k_adj;
    logic                  past_end;
    logic [CNT_W-1:0]      fill_m1;

    // shared index unit
    assign step_up  = (state_reg == pls_pkg::ST_REM_CHK) || (state_reg == pls_pkg::ST_REM_MOV);
    assign k_adj    = step_up ? k_reg + CNT_W'(1) : k_reg - CNT_W'(1);
    assign past_end = (in_position >= fill_reg);
    assign fill_m1  = fill_reg - CNT_W'(1);

    assign in_ready       = (state_reg == pls_pkg::ST_IDLE);
    assign res_valid      = (state_reg == pls_pkg::ST_DONE);
    assign res_status     = status_reg;
    assign res_read_value = rdval_reg;
    assign res_count      = fill_reg;
    assign res_first      = first_reg;
    assign res_last       = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pls_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_func)
                        pls_pkg::FN_INSERT:
                            state_next = (fill_reg == CNT_W'(DEPTH)) ? pls_pkg::ST_FIRST
                                                                     : pls_pkg::ST_INS_CHK;
                        pls_pkg::FN_REMOVE:
                            state_next = (fill_reg == '0) ? pls_pkg::ST_FIRST
                                                          : pls_pkg::ST_REM_CHK;
                        pls_pkg::FN_READ:
                            state_next = past_end ? pls_pkg::ST_FIRST : pls_pkg::ST_RD_WAIT;
                        default:
                            state_next = pls_pkg::ST_FIRST;
                    endcase
                end
            end
            pls_pkg::ST_INS_CHK:
                state_next = (k_reg > pos_reg) ? pls_pkg::ST_INS_MOV : pls_pkg::ST_FIRST;
            pls_pkg::ST_INS_MOV:
                state_next = pls_pkg::ST_INS_CHK;
            pls_pkg::ST_REM_CHK:
                state_next = (k_adj < fill_reg) ? pls_pkg::ST_REM_MOV : pls_pkg::ST_FIRST;
            pls_pkg::ST_REM_MOV:
                state_next = pls_pkg::ST_REM_CHK;
            pls_pkg::ST_RD_WAIT:
                state_next = pls_pkg::ST_FIRST;
            pls_pkg::ST_FIRST:
                state_next = (fill_reg == '0) ? pls_pkg::ST_DONE : pls_pkg::ST_LAST;
            pls_pkg::ST_LAST:
                state_next = pls_pkg::ST_LAST_WAIT;
            pls_pkg::ST_LAST_WAIT:
                state_next = pls_pkg::ST_DONE;
            pls_pkg::ST_DONE:
                state_next = res_ready ? pls_pkg::ST_IDLE : pls_pkg::ST_DONE;
            default:
                state_next = pls_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        fill_next   = fill_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        we          = 1'b0;
        waddr       = k_reg[IDX_W-1:0];
        wdata       = rdata_reg;
        raddr       = k_adj[IDX_W-1:0];
        unique case (state_reg)
            pls_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next  = in_value;
                    rdval_next  = '0;
                    status_next = pls_pkg::STS_OK;
                    case (in_func)
                        pls_pkg::FN_INSERT:
                        begin
                            if (fill_reg == CNT_W'(DEPTH))
                                status_next = pls_pkg::STS_FULL;
                            else
                            begin
                                pos_next = past_end ? fill_reg : in_position;
                                k_next   = fill_reg;
                            end
                        end
                        pls_pkg::FN_REMOVE:
                        begin
                            if (fill_reg == '0)
                                status_next = pls_pkg::STS_EMPTY;
                            else
                            begin
                                pos_next = past_end ? fill_m1 : in_position;
                                k_next   = past_end ? fill_m1 : in_position;
                            end
                        end
                        pls_pkg::FN_READ:
                        begin
                            if (past_end)
                                status_next = pls_pkg::STS_RANGE;
                            else
                                raddr = in_position[IDX_W-1:0];
                        end
                        default:
                            status_next = pls_pkg::STS_OK;
                    endcase
                end
            end
            pls_pkg::ST_INS_CHK:
            begin
                if (!(k_reg > pos_reg))
                begin
                    we        = 1'b1;
                    waddr     = pos_reg[IDX_W-1:0];
                    wdata     = value_reg;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            pls_pkg::ST_INS_MOV:
            begin
                we     = 1'b1;
                k_next = k_adj;
            end
            pls_pkg::ST_REM_CHK:
            begin
                if (!(k_adj < fill_reg))
                    fill_next = fill_m1;
            end
            pls_pkg::ST_REM_MOV:
            begin
                we     = 1'b1;
                k_next = k_adj;
            end
            pls_pkg::ST_RD_WAIT:
                rdval_next = rdata_reg;
            pls_pkg::ST_FIRST:
            begin
                raddr = '0;
                if (fill_reg == '0)
                begin
                    first_next = '0;
                    last_next  = '0;
                end
            end
            pls_pkg::ST_LAST:
            begin
                first_next = rdata_reg;
                raddr      = fill_m1[IDX_W-1:0];
            end
            pls_pkg::ST_LAST_WAIT:
                last_next = rdata_reg;
            pls_pkg::ST_DONE:
                rdval_next = rdval_reg;
            default:
                rdval_next = rdval_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pls_pkg::ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
    end

    // element memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            slots[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= slots[raddr];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_fill_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pls_pkg::ST_INS_CHK && state_reg != pls_pkg::ST_REM_CHK)
        |=> $stable(fill_reg))
        else $error("element count changed outside the end of a shift");

    a_ins_move_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pls_pkg::ST_INS_MOV |-> (k_reg > pos_reg && k_reg < CNT_W'(DEPTH)))
        else $error("insert move outside the shifted range");

    a_rem_move_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pls_pkg::ST_REM_MOV
        |-> ({1'b0, k_reg} + (CNT_W + 1)'(1) < {1'b0, fill_reg}))
        else $error("remove move outside the stored elements");

endmodule

// ===== src/positional_list_store.sv =====
// top level of the positional list store: stream ports and output register
//
// A bounded ordered list of up to DEPTH words. Each input word inserts, removes or reads
// one element at a position; for an insert or a remove, positions at or past the count
// mean the end of the list, and a read there returns the range status. Every result word
// carries the status, the read element, the count and the first and last elements. The
// block works on one word at a time and drops s_axis_tready until it is done. Elements
// sit in a single-port-read memory, so every element moved by an insert or a remove is
// read by a check state and written back one place over by a move state. Before the
// result, the first and then the last element are fetched, both skipped when the list
// ends up empty. A finished result waits in the output register, so the next word is
// accepted while it is still pending.
module positional_list_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((CNT_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((3 * DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // position, value
    input  logic [1:0]       s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // read_value, element_count, first_value, last_value
    output logic [1:0]       m_axis_tuser    // status
);

    logic                  res_valid;
    logic                  res_ready;
    logic [1:0]            res_status;
    logic [DATA_WIDTH-1:0] res_read_value;
    logic [CNT_W-1:0]      res_count;
    logic [DATA_WIDTH-1:0] res_first;
    logic [DATA_WIDTH-1:0] res_last;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [DATA_WIDTH-1:0] out_rdval_reg, out_rdval_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;
    logic [DATA_WIDTH-1:0] out_first_reg, out_first_next;
    logic [DATA_WIDTH-1:0] out_last_reg, out_last_next;

    pls_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_func        (s_axis_tuser),
        .in_position    (s_axis_tdata[CNT_W-1:0]),
        .in_value       (s_axis_tdata[CNT_W +: DATA_WIDTH]),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_status     (res_status),
        .res_read_value (res_read_value),
        .res_count      (res_count),
        .res_first      (res_first),
        .res_last       (res_last)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rdval_next  = out_rdval_reg;
        out_count_next  = out_count_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (res_valid && res_ready)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_rdval_next  = res_read_value;
            out_count_next  = res_count;
            out_first_next  = res_first;
            out_last_next   = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_rdval_reg  <= out_rdval_next;
        out_count_reg  <= out_count_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_W'({out_last_reg, out_first_reg, out_count_reg, out_rdval_reg});

endmodule
